FILE: design/rdc_pkg.sv
// Shared constants, widths and controller/datapath interface structs for the
// range distinct count engine. No dependencies.

package rdc_pkg;

    localparam int ARRAY_DEPTH = 1024;
    localparam int VALUE_RANGE = 1024;

    localparam int POS_W = $clog2(ARRAY_DEPTH);
    localparam int VAL_W = $clog2(VALUE_RANGE);
    localparam int CNT_W = $clog2(ARRAY_DEPTH + 1);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [CNT_W-1:0] LOAD_LIMIT = CNT_W'(ARRAY_DEPTH);
    localparam logic [VAL_W-1:0] CLEAR_LAST = VAL_W'(VALUE_RANGE - 1);

    typedef struct packed {
        logic clear_en;
        logic load;
        logic capture;
        logic step;
        logic hist_rd;
        logic upd;
        logic emit;
    } rdc_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic query_ok;
        logic move_needed;
        logic out_free;
    } rdc_status_t;

endpackage

FILE: design/rdc_ctrl.sv
// Controller state machine of the range distinct count engine.
// Depends on rdc_pkg for the command and status structs.

module rdc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_mode,
    output logic                 in_ready,
    input  rdc_pkg::rdc_status_t status,
    output rdc_pkg::rdc_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_STEP  = 7'b0001000,
        S_HIST  = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_CHECK;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = status.query_ok ? S_STEP : S_EMIT;
            end
            S_STEP:
            begin
                if (status.move_needed)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_HIST;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_HIST:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_STEP;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: design/rdc_datapath.sv
// Datapath of the range distinct count engine: element store, value histogram,
// window pointers, distinct counter and the output word register. Depends on rdc_pkg.

module rdc_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rdc_pkg::rdc_cmd_t          cmd,
    output rdc_pkg::rdc_status_t       status,
    input  logic [rdc_pkg::VAL_W-1:0]  in_value,
    input  logic [rdc_pkg::POS_W-1:0]  in_left,
    input  logic [rdc_pkg::POS_W-1:0]  in_right,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [rdc_pkg::CNT_W-1:0]  out_count,
    output logic                       out_query_valid
);

    localparam int POS_W = rdc_pkg::POS_W;
    localparam int VAL_W = rdc_pkg::VAL_W;
    localparam int CNT_W = rdc_pkg::CNT_W;

    logic [VAL_W-1:0] store_mem [rdc_pkg::ARRAY_DEPTH];
    logic [CNT_W-1:0] hist_mem  [rdc_pkg::VALUE_RANGE];

    logic [VAL_W-1:0]        store_rdata_reg;
    logic [CNT_W-1:0]        hist_rdata_reg;
    logic [VAL_W-1:0]        clr_addr_reg;
    logic [CNT_W-1:0]        loaded_count_reg;
    logic [POS_W-1:0]        left_reg;
    logic signed [POS_W:0]   right_reg;
    logic [CNT_W-1:0]        distinct_reg;
    logic [POS_W-1:0]        lq_reg;
    logic [POS_W-1:0]        rq_reg;
    logic                    enter_reg;
    logic                    out_valid_reg;
    logic [CNT_W-1:0]        out_count_reg;
    logic                    out_qv_reg;

    logic signed [POS_W:0]   rq_s;
    logic                    grow_r;
    logic                    grow_l;
    logic                    shrink_r;
    logic                    shrink_l;
    logic [POS_W-1:0]        step_pos;
    logic [CNT_W-1:0]        hist_new;
    logic [CNT_W-1:0]        distinct_new;

    // Window movement in the same priority as the four pointer sweeps.
    assign rq_s     = $signed({1'b0, rq_reg});
    assign grow_r   = right_reg < rq_s;
    assign grow_l   = left_reg > lq_reg;
    assign shrink_r = right_reg > rq_s;
    assign shrink_l = left_reg < lq_reg;

    always_comb
    begin
        if (grow_r)
        begin
            step_pos = right_reg[POS_W-1:0] + 1'b1;
        end
        else if (grow_l)
        begin
            step_pos = left_reg - 1'b1;
        end
        else if (shrink_r)
        begin
            step_pos = right_reg[POS_W-1:0];
        end
        else
        begin
            step_pos = left_reg;
        end
    end

    // Histogram update; a removal from an empty bin is ignored.
    always_comb
    begin
        hist_new     = hist_rdata_reg;
        distinct_new = distinct_reg;
        if (enter_reg)
        begin
            hist_new = hist_rdata_reg + 1'b1;
            if (hist_rdata_reg == '0)
            begin
                distinct_new = distinct_reg + 1'b1;
            end
        end
        else if (hist_rdata_reg != '0)
        begin
            hist_new = hist_rdata_reg - 1'b1;
            if (hist_new == '0 && distinct_reg != '0)
            begin
                distinct_new = distinct_reg - 1'b1;
            end
        end
    end

    assign status.clear_done  = (clr_addr_reg == rdc_pkg::CLEAR_LAST);
    assign status.query_ok    = (lq_reg <= rq_reg) && ({1'b0, rq_reg} < loaded_count_reg);
    assign status.move_needed = grow_r | grow_l | shrink_r | shrink_l;
    assign status.out_free    = !out_valid_reg || out_ready;

    // Element store: append port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load && loaded_count_reg < rdc_pkg::LOAD_LIMIT)
        begin
            store_mem[loaded_count_reg[POS_W-1:0]] <= in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            store_rdata_reg <= store_mem[step_pos];
        end
    end

    // Histogram: cleared by a sweep after reset, then read-modify-write per step.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            hist_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.upd)
        begin
            hist_mem[store_rdata_reg] <= hist_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd)
        begin
            hist_rdata_reg <= hist_mem[store_rdata_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lq_reg <= in_left;
            rq_reg <= in_right;
        end
        if (cmd.step)
        begin
            enter_reg <= grow_r | grow_l;
        end
        if (cmd.emit)
        begin
            out_count_reg <= status.query_ok ? distinct_reg : '0;
            out_qv_reg    <= status.query_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            loaded_count_reg <= '0;
            left_reg         <= '0;
            right_reg        <= '1;
            distinct_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load && loaded_count_reg < rdc_pkg::LOAD_LIMIT)
            begin
                loaded_count_reg <= loaded_count_reg + 1'b1;
            end
            if (cmd.step)
            begin
                if (grow_r)
                begin
                    right_reg <= right_reg + (POS_W+1)'(1);
                end
                else if (grow_l)
                begin
                    left_reg <= left_reg - 1'b1;
                end
                else if (shrink_r)
                begin
                    right_reg <= right_reg - (POS_W+1)'(1);
                end
                else
                begin
                    left_reg <= left_reg + 1'b1;
                end
            end
            if (cmd.upd)
            begin
                distinct_reg <= distinct_new;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_count       = out_count_reg;
    assign out_query_valid = out_qv_reg;

endmodule

FILE: design/range_distinct_count_engine_core.sv
// Top level of the range distinct count engine: stream ports, field packing and
// the controller and datapath instances. Depends on rdc_pkg, rdc_ctrl, rdc_datapath.
//
//   Channel  Direction  Contents
//   s_*      in         one word: a load (value) or a range query (left, right)
//   m_*      out        one word per query: distinct count and query valid flag
//
// After reset the histogram is cleared by a sweep over every bin, during which
// s_tready stays low. A load keeps the controller idle. A query goes through S_CHECK,
// then S_STEP, S_HIST and S_UPD once per element that enters or leaves the window,
// then S_EMIT; each such step is a store read, a histogram read and a histogram
// write. A rejected query goes from S_CHECK to S_EMIT. A pending result in the output
// register does not block further loads; a finished query waits until it is free.

module range_distinct_count_engine_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: value[9:0], left_pos[19:10], right_pos[29:20], zero pad.
    input  logic [rdc_pkg::IN_DATA_W-1:0]     s_tdata,
    // Fields from bit 0: mode (0 load, 1 query).
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: distinct_count[10:0], query_valid[11], zero pad.
    output logic [rdc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int POS_W = rdc_pkg::POS_W;
    localparam int VAL_W = rdc_pkg::VAL_W;
    localparam int CNT_W = rdc_pkg::CNT_W;

    rdc_pkg::rdc_cmd_t    cmd;
    rdc_pkg::rdc_status_t status;

    logic [CNT_W-1:0] out_count;
    logic             out_query_valid;

    rdc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rdc_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_value        (s_tdata[VAL_W-1:0]),
        .in_left         (s_tdata[10 +: POS_W]),
        .in_right        (s_tdata[20 +: POS_W]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_count       (out_count),
        .out_query_valid (out_query_valid)
    );

    // The output word carries the count in the low bits and the flag just above.
    assign m_tdata = {{(rdc_pkg::OUT_DATA_W - CNT_W - 1){1'b0}}, out_query_valid, out_count};

endmodule

FILE: test/range_distinct_count_engine_core_tb.sv
// Self-checking testbench for range_distinct_count_engine_core: loads and range queries
// go in, predicted distinct counts are compared with the words that come out.
// Depends on rdc_pkg and the design files; needs no other input.

module range_distinct_count_engine_core_tb;

    localparam int POS_W       = rdc_pkg::POS_W;
    localparam int VAL_W       = rdc_pkg::VAL_W;
    localparam int CNT_W       = rdc_pkg::CNT_W;
    localparam int ARRAY_DEPTH = rdc_pkg::ARRAY_DEPTH;
    localparam int VALUE_RANGE = rdc_pkg::VALUE_RANGE;
    localparam int IN_DATA_W   = rdc_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = rdc_pkg::OUT_DATA_W;

    // Word types as they travel on the stream ports.
    typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} op_t;

    typedef struct packed {
        logic [POS_W-1:0] right_pos;
        logic [POS_W-1:0] left_pos;
        logic [VAL_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic             query_valid;
        logic [CNT_W-1:0] distinct_count;
    } out_word_t;

    localparam int ITEMS         = 1800;
    localparam int PRESSURE_ITEM = 500;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_LEN     = 200;
    localparam int MAX_REPORTS   = 10;
    localparam longint LIMIT     = 40_000_000;

    // Distinct count predictor with its own window state and histogram. Every
    // accepted query pushes one expected word; every output word pops one.
    class distinct_scoreboard;
        logic [VAL_W-1:0] elem_mem [ARRAY_DEPTH];
        int unsigned      occur [VALUE_RANGE];
        int               loaded;
        int               win_l;
        int               win_r;
        int unsigned      distinct;
        out_word_t        expected_q [$];
        int               errors;

        function new();
            loaded   = 0;
            win_l    = 0;
            win_r    = -1;
            distinct = 0;
            errors   = 0;
            foreach (occur[i])
                occur[i] = 0;
        endfunction

        function void enter_pos(int p);
            logic [VAL_W-1:0] v;
            v = elem_mem[p];
            if (occur[v] == 0)
                distinct++;
            occur[v]++;
        endfunction

        function void leave_pos(int p);
            logic [VAL_W-1:0] v;
            v = elem_mem[p];
            if (occur[v] == 0)
                return;
            occur[v]--;
            if (occur[v] == 0 && distinct > 0)
                distinct--;
        endfunction

        function void note_word(op_t op, in_word_t w);
            out_word_t res;
            int        lq;
            int        rq;
            lq = w.left_pos;
            rq = w.right_pos;
            if (op == OP_LOAD)
            begin
                // A full store silently drops further loads.
                if (loaded < ARRAY_DEPTH)
                begin
                    elem_mem[loaded] = w.value;
                    loaded++;
                end
                return;
            end
            res = '0;
            if (lq <= rq && rq < loaded)
            begin
                // Grow the window first, then shrink it, one position at a time.
                while (win_r < rq)
                begin
                    win_r++;
                    enter_pos(win_r);
                end
                while (win_l > lq)
                begin
                    win_l--;
                    enter_pos(win_l);
                end
                while (win_r > rq)
                begin
                    leave_pos(win_r);
                    win_r--;
                end
                while (win_l < lq)
                begin
                    leave_pos(win_l);
                    win_l++;
                end
                res.distinct_count = distinct[CNT_W-1:0];
                res.query_valid    = 1'b1;
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            out_word_t got;
            out_word_t want;
            got = data[$bits(out_word_t)-1:0];
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: unexpected output word count=%0d valid=%0b",
                             got.distinct_count, got.query_valid);
                return;
            end
            want = expected_q.pop_front();
            if (got.distinct_count !== want.distinct_count ||
                got.query_valid !== want.query_valid)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected count=%0d valid=%0b, got count=%0d valid=%0b",
                             want.distinct_count, want.query_valid,
                             got.distinct_count, got.query_valid);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    distinct_scoreboard sb = new();

    int     sent_count = 0;
    int     send_idle = 0;
    int     recv_stall = 0;
    int     hold_left = 0;
    bit     pressure_done = 1'b0;
    longint cycles = 0;

    // Last accepted query window, used to steer the random queries along a
    // sliding path so that most of them move the window only a few positions.
    int cur_l = 0;
    int cur_r = 0;

    always #1 clk = ~clk;

    range_distinct_count_engine_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Output side: random stalls, plus one long hold-off once the sender has
    // passed a set number of words, so that a second finished query backs up.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!pressure_done && sent_count >= PRESSURE_ITEM)
        begin
            pressure_done <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_tready      <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAIL range_distinct_count_engine_core");
            $finish;
        end
    end

    // Offers one word after a random gap and waits for the handshake. The
    // idling profile rotates every few hundred words.
    task automatic send_word(input op_t op, input int value, input int lpos, input int rpos);
        int       gap;
        in_word_t w;
        case ((sent_count / PHASE_LEN) % 4)
            0:
            begin
                send_idle  = 0;
                recv_stall = 0;
            end
            1:
            begin
                send_idle  = 71;
                recv_stall = 0;
            end
            2:
            begin
                send_idle  = 0;
                recv_stall = 71;
            end
            default:
            begin
                send_idle  = 35;
                recv_stall = 35;
            end
        endcase
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.value     = value[VAL_W-1:0];
        w.left_pos  = lpos[POS_W-1:0];
        w.right_pos = rpos[POS_W-1:0];
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(w);
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(op, w);
        sent_count++;
    endtask

    task automatic load_word(input int value);
        send_word(OP_LOAD, value, $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic query_word(input int lpos, input int rpos);
        send_word(OP_QUERY, $urandom_range(1023), lpos, rpos);
        if (lpos <= rpos && rpos < sb.loaded)
        begin
            cur_l = lpos;
            cur_r = rpos;
        end
    endtask

    // Random query: mostly small moves of both window ends, some long jumps,
    // some ranges that must be rejected.
    task automatic random_query();
        int roll;
        int n;
        int l;
        int r;
        roll = $urandom_range(99);
        n    = sb.loaded;
        if (n == 0 || roll < 10)
        begin
            if (n < ARRAY_DEPTH && $urandom_range(1) == 1)
            begin
                r = $urandom_range(1023, n);
                l = $urandom_range(r, 0);
            end
            else
            begin
                l = $urandom_range(1023, 1);
                r = $urandom_range(l - 1, 0);
            end
        end
        else if (roll < 15)
        begin
            r = $urandom_range(n - 1, 0);
            l = $urandom_range(r, 0);
        end
        else
        begin
            r = cur_r + $urandom_range(12) - 4;
            if (r < 0)
                r = 0;
            if (r > n - 1)
                r = n - 1;
            l = cur_l + $urandom_range(12) - 4;
            if (l < 0)
                l = 0;
            if (l > r)
                l = r;
        end
        query_word(l, r);
    endtask

    function automatic int random_value();
        // Half of the values come from a narrow set so that repeats pile up
        // in the histogram.
        if ($urandom_range(1) == 1)
            return $urandom_range(1023);
        return $urandom_range(15);
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block sweeps its histogram after reset; the first
        // handshake simply waits for it.
        query_word(0, 0);           // nothing loaded yet
        load_word(0);
        load_word(1023);
        load_word(1023);
        load_word(512);
        load_word(5);
        load_word(0);
        query_word(0, 5);           // whole store, repeats inside
        query_word(0, 5);           // same window, no movement
        query_word(5, 5);
        query_word(1, 2);           // two equal values
        query_word(3, 1);           // inverted range
        query_word(0, 6);           // right end not loaded yet
        query_word(1023, 0);        // inverted, extreme ends
        query_word(0, 1023);        // far beyond the loaded part
        query_word(2, 4);
        query_word(0, 0);
        load_word(1);               // a load leaves the window in place
        query_word(6, 6);
        query_word(0, 6);

        // Random part: loads dominate until the store is full, then queries.
        while (sent_count < ITEMS - 8)
        begin
            if (sb.loaded < ARRAY_DEPTH)
            begin
                if ($urandom_range(99) < 70)
                    load_word(random_value());
                else
                    random_query();
            end
            else
            begin
                if ($urandom_range(99) < 5)
                    load_word(random_value());
                else
                    random_query();
            end
        end

        // Fill the store if the random part left room, then hit the top end.
        while (sb.loaded < ARRAY_DEPTH)
            load_word(random_value());
        load_word(1023);            // store full: dropped
        query_word(1023, 1023);
        query_word(0, 1023);
        query_word(512, 700);
        query_word(1023, 0);
        query_word(0, 1023);
        query_word(1023, 1023);

        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS range_distinct_count_engine_core");
        else
            $display("FAIL range_distinct_count_engine_core");
        $finish;
    end

endmodule
